@@ src/hover_readiness_qualifier_defines.svh @@
// Assertion macros shared by the hover readiness qualifier RTL.
`ifndef HOVER_READINESS_QUALIFIER_DEFINES_SVH
`define HOVER_READINESS_QUALIFIER_DEFINES_SVH

`ifndef SYNTH
// clocked check, held off while reset is asserted
`define HRQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hrq assertion failed");
// clocked check that also holds through reset
`define HRQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hrq assertion failed");
`else
`define HRQ_ASSERT(lbl, clk, rst_n, prop)
`define HRQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ src/hrq_pkg.sv @@
// Shared types and constants for the hover readiness qualifier.
package hrq_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [2:0] REG_BASELINE   = 3'd0;
  localparam logic [2:0] REG_MICRO      = 3'd1;
  localparam logic [2:0] REG_MIN_RISE   = 3'd2;
  localparam logic [2:0] REG_FLOW_GATE  = 3'd3;
  localparam logic [2:0] REG_FLOW_QUAL  = 3'd4;
  localparam logic [2:0] REG_ATT_LIMIT  = 3'd5;
  localparam logic [2:0] REG_RANGE_INV  = 3'd6;
  localparam logic [2:0] REG_FLAP_LIMIT = 3'd7;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [7:0] FRESH_SAMPLES = 8'd3;
  localparam logic [7:0] RISE_SAMPLES  = 8'd3;
  localparam logic [7:0] FLOW_SAMPLES  = 8'd3;
  localparam logic [7:0] QUIET_SAMPLES = 8'd3;
  localparam logic [7:0] STALE_SAMPLES = 8'd5;
  localparam logic [7:0] CNT_MAX       = 8'hFF;

  typedef struct packed {
    logic [15:0] baseline_height_mm;
    logic [15:0] micro_height_mm;
    logic [15:0] min_rise_mm;
    logic [15:0] flow_gate_height_mm;
    logic [15:0] flow_min_quality;
    logic [14:0] attitude_limit_cdeg;
    logic [15:0] range_invalid_mm;
    logic [7:0]  flap_limit;
  } cfg_t;

  typedef struct packed {
    logic fresh;
    logic risen;
    logic flow;
    logic quiet;
    logic missing;
  } cond_t;

  typedef struct packed {
    logic       range_live;
    logic       flow_live;
    logic       attitude_settled;
    logic       truth_stale;
    logic       flapping;
    logic [7:0] flap_count;
  } res_t;

endpackage

@@ src/hrq_cfg_regs.sv @@
// Configuration register bank behind the APB-style port.
module hrq_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [hrq_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [hrq_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [hrq_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready,
  output hrq_pkg::cfg_t                    cfg
);

  hrq_pkg::cfg_t cfg_r;
  hrq_pkg::cfg_t cfg_nxt;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx        = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        hrq_pkg::REG_BASELINE:   cfg_nxt.baseline_height_mm  = cfg_pwdata[15:0];
        hrq_pkg::REG_MICRO:      cfg_nxt.micro_height_mm     = cfg_pwdata[15:0];
        hrq_pkg::REG_MIN_RISE:   cfg_nxt.min_rise_mm         = cfg_pwdata[15:0];
        hrq_pkg::REG_FLOW_GATE:  cfg_nxt.flow_gate_height_mm = cfg_pwdata[15:0];
        hrq_pkg::REG_FLOW_QUAL:  cfg_nxt.flow_min_quality    = cfg_pwdata[15:0];
        hrq_pkg::REG_ATT_LIMIT:  cfg_nxt.attitude_limit_cdeg = cfg_pwdata[14:0];
        hrq_pkg::REG_RANGE_INV:  cfg_nxt.range_invalid_mm    = cfg_pwdata[15:0];
        hrq_pkg::REG_FLAP_LIMIT: cfg_nxt.flap_limit          = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      hrq_pkg::REG_BASELINE:   cfg_prdata = {16'd0, cfg_r.baseline_height_mm};
      hrq_pkg::REG_MICRO:      cfg_prdata = {16'd0, cfg_r.micro_height_mm};
      hrq_pkg::REG_MIN_RISE:   cfg_prdata = {16'd0, cfg_r.min_rise_mm};
      hrq_pkg::REG_FLOW_GATE:  cfg_prdata = {16'd0, cfg_r.flow_gate_height_mm};
      hrq_pkg::REG_FLOW_QUAL:  cfg_prdata = {16'd0, cfg_r.flow_min_quality};
      hrq_pkg::REG_ATT_LIMIT:  cfg_prdata = {17'd0, cfg_r.attitude_limit_cdeg};
      hrq_pkg::REG_RANGE_INV:  cfg_prdata = {16'd0, cfg_r.range_invalid_mm};
      hrq_pkg::REG_FLAP_LIMIT: cfg_prdata = {24'd0, cfg_r.flap_limit};
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.baseline_height_mm  <= 16'd0;
      cfg_r.micro_height_mm     <= 16'd0;
      cfg_r.min_rise_mm         <= 16'd50;
      cfg_r.flow_gate_height_mm <= 16'd100;
      cfg_r.flow_min_quality    <= 16'd30;
      cfg_r.attitude_limit_cdeg <= 15'd1000;
      cfg_r.range_invalid_mm    <= 16'd8000;
      cfg_r.flap_limit          <= 8'd4;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ src/hrq_judge.sv @@
// Per-sample condition evaluation: fresh, risen, flow ready, quiet, missing.
module hrq_judge (
  input  hrq_pkg::cfg_t      cfg,
  input  logic [15:0]        down_range_mm,
  input  logic [15:0]        motion_quality,
  input  logic signed [15:0] roll_cdeg,
  input  logic signed [15:0] pitch_cdeg,
  input  logic               hover_phase,
  output hrq_pkg::cond_t     cond
);

  logic [15:0] need;
  logic [16:0] roll_mag;
  logic [16:0] pitch_mag;
  logic [16:0] att_lim;

  // rise threshold wraps at 16 bits
  assign need = cfg.baseline_height_mm + cfg.min_rise_mm;

  // -32768 becomes 32768, which no 15-bit limit can reach
  assign roll_mag  = roll_cdeg[15] ? (17'h10000 - {1'b0, roll_cdeg}) : {1'b0, roll_cdeg};
  assign pitch_mag = pitch_cdeg[15] ? (17'h10000 - {1'b0, pitch_cdeg}) : {1'b0, pitch_cdeg};
  assign att_lim   = {2'b00, cfg.attitude_limit_cdeg};

  always_comb begin
    cond.fresh   = (down_range_mm != 16'd0) && (down_range_mm < cfg.range_invalid_mm);
    cond.risen   = cond.fresh && (down_range_mm >= cfg.micro_height_mm) &&
                   (down_range_mm >= need);
    cond.flow    = cond.fresh && (down_range_mm >= cfg.flow_gate_height_mm) &&
                   (motion_quality >= cfg.flow_min_quality);
    cond.quiet   = (roll_mag <= att_lim) && (pitch_mag <= att_lim);
    cond.missing = hover_phase && (!cond.fresh || !cond.flow);
  end

endmodule

@@ src/hrq_track.sv @@
// Run counters, flap counter and previous-condition history; result flags.
module hrq_track (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  logic           clear,
  input  hrq_pkg::cond_t cond,
  input  logic [7:0]     flap_limit,
  output hrq_pkg::res_t  res
);

  logic [7:0] fresh_cnt_r,  fresh_cnt_nxt;
  logic [7:0] rise_cnt_r,   rise_cnt_nxt;
  logic [7:0] flow_cnt_r,   flow_cnt_nxt;
  logic [7:0] quiet_cnt_r,  quiet_cnt_nxt;
  logic [7:0] stale_cnt_r,  stale_cnt_nxt;
  logic [7:0] flap_cnt_r,   flap_cnt_nxt;
  logic [3:0] prev_cond_r,  prev_cond_nxt;
  logic [3:0] now_cond;
  logic       regressed;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == hrq_pkg::CNT_MAX) ? v : v + 8'd1;
  endfunction

  assign now_cond  = {cond.quiet, cond.flow, cond.risen, cond.fresh};
  assign regressed = |(prev_cond_r & ~now_cond);

  always_comb begin
    if (clear) begin
      fresh_cnt_nxt = '0;
      rise_cnt_nxt  = '0;
      flow_cnt_nxt  = '0;
      quiet_cnt_nxt = '0;
      stale_cnt_nxt = '0;
      flap_cnt_nxt  = '0;
      prev_cond_nxt = '0;
    end else begin
      fresh_cnt_nxt = cond.fresh   ? sat_inc(fresh_cnt_r) : 8'd0;
      rise_cnt_nxt  = cond.risen   ? sat_inc(rise_cnt_r)  : 8'd0;
      flow_cnt_nxt  = cond.flow    ? sat_inc(flow_cnt_r)  : 8'd0;
      quiet_cnt_nxt = cond.quiet   ? sat_inc(quiet_cnt_r) : 8'd0;
      stale_cnt_nxt = cond.missing ? sat_inc(stale_cnt_r) : 8'd0;
      flap_cnt_nxt  = regressed    ? sat_inc(flap_cnt_r)  : flap_cnt_r;
      prev_cond_nxt = now_cond;
    end
  end

  // flags come from the post-update counts
  always_comb begin
    res.range_live       = (fresh_cnt_nxt >= hrq_pkg::FRESH_SAMPLES) &&
                           (rise_cnt_nxt >= hrq_pkg::RISE_SAMPLES);
    res.flow_live        = flow_cnt_nxt >= hrq_pkg::FLOW_SAMPLES;
    res.attitude_settled = quiet_cnt_nxt >= hrq_pkg::QUIET_SAMPLES;
    res.truth_stale      = stale_cnt_nxt >= hrq_pkg::STALE_SAMPLES;
    res.flapping         = flap_cnt_nxt >= flap_limit;
    res.flap_count       = flap_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_cnt_r <= '0;
      rise_cnt_r  <= '0;
      flow_cnt_r  <= '0;
      quiet_cnt_r <= '0;
      stale_cnt_r <= '0;
      flap_cnt_r  <= '0;
      prev_cond_r <= '0;
    end else if (step) begin
      fresh_cnt_r <= fresh_cnt_nxt;
      rise_cnt_r  <= rise_cnt_nxt;
      flow_cnt_r  <= flow_cnt_nxt;
      quiet_cnt_r <= quiet_cnt_nxt;
      stale_cnt_r <= stale_cnt_nxt;
      flap_cnt_r  <= flap_cnt_nxt;
      prev_cond_r <= prev_cond_nxt;
    end
  end

endmodule

@@ src/hover_readiness_qualifier.sv @@
// Hover readiness qualifier top level: input register, judge, tracker, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one sensor sample item or a
//   clear command per accepted cycle. Result channel (out_valid / out_stall)
//   returns exactly one result item per input item, in order. Each item
//   passes two register stages: the input register, then the result
//   register. Throughput: one item per cycle while the receiver does not
//   stall; the counters update in the cycle the item moves from the input
//   register to the result register. When the receiver stalls, the result
//   register holds and one more item waits in the input register; in_stall
//   rises only when both are full. Configuration registers sit on the cfg_
//   APB-style port (byte address 4*i, pready tied high) and are to be
//   written only while the block is idle, a user rule the block does not
//   enforce. Reset (rst_n low, synchronous) empties both stages, zeroes all
//   counters and history, and loads the register defaults.
`include "hover_readiness_qualifier_defines.svh"

module hover_readiness_qualifier (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [15:0]                    in_down_range_mm,
  input  logic [15:0]                    in_motion_quality,
  input  logic signed [15:0]             in_roll_cdeg,
  input  logic signed [15:0]             in_pitch_cdeg,
  input  logic                           in_hover_phase,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_range_live,
  output logic                           out_flow_live,
  output logic                           out_attitude_settled,
  output logic                           out_truth_stale,
  output logic                           out_flapping,
  output logic [7:0]                     out_flap_count,

  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [hrq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [hrq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [hrq_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  hrq_pkg::cfg_t      cfg;
  hrq_pkg::cond_t     cond;
  hrq_pkg::res_t      res;

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_op_r;
  logic [15:0]        s1_range_r;
  logic [15:0]        s1_quality_r;
  logic signed [15:0] s1_roll_r;
  logic signed [15:0] s1_pitch_r;
  logic               s1_hover_r;

  logic               out_valid_r, out_valid_nxt;
  hrq_pkg::res_t      out_res_r;

  logic               in_take;
  logic               adv;

  hrq_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hrq_judge u_judge (
    .cfg            (cfg),
    .down_range_mm  (s1_range_r),
    .motion_quality (s1_quality_r),
    .roll_cdeg      (s1_roll_r),
    .pitch_cdeg     (s1_pitch_r),
    .hover_phase    (s1_hover_r),
    .cond           (cond)
  );

  hrq_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (adv),
    .clear      (s1_op_r == hrq_pkg::OP_CLEAR),
    .cond       (cond),
    .flap_limit (cfg.flap_limit),
    .res        (res)
  );

  // item moves on when the result register is empty or being drained
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take || (s1_valid_r && !adv);
    out_valid_nxt = adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r      <= in_opcode;
      s1_range_r   <= in_down_range_mm;
      s1_quality_r <= in_motion_quality;
      s1_roll_r    <= in_roll_cdeg;
      s1_pitch_r   <= in_pitch_cdeg;
      s1_hover_r   <= in_hover_phase;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_range_live       = out_res_r.range_live;
  assign out_flow_live        = out_res_r.flow_live;
  assign out_attitude_settled = out_res_r.attitude_settled;
  assign out_truth_stale      = out_res_r.truth_stale;
  assign out_flapping         = out_res_r.flapping;
  assign out_flap_count       = out_res_r.flap_count;

  `HRQ_ASSERT(a_adv_fills_out, clk, rst_n, adv |=> out_valid_r)
  `HRQ_ASSERT(a_held_item_kept, clk, rst_n, (s1_valid_r && !adv) |=> s1_valid_r)
  `HRQ_ASSERT(a_clear_zeroes, clk, rst_n,
    (adv && s1_op_r == hrq_pkg::OP_CLEAR) |=> (out_flap_count == 8'd0 && !out_range_live))
  `HRQ_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!s1_valid_r && !out_valid_r))

endmodule
